// ===== rtl/inverted_page_table_lru_top_defines.svh =====
// assertion macros for the inverted page table
`ifndef INVERTED_PAGE_TABLE_LRU_TOP_DEFINES_SVH
`define INVERTED_PAGE_TABLE_LRU_TOP_DEFINES_SVH

// implication checked on every rising clock edge out of reset
`define IPT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define IPT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/iptlru_pkg.sv =====
// ----------------------------------------------------------------------------
// iptlru_pkg
// types, codes and defaults shared by the inverted page table modules
// ----------------------------------------------------------------------------
`default_nettype none
package iptlru_pkg;

  localparam int FramesDef   = 32;
  localparam int PageBitsDef = 12;
  localparam int AsidBitsDef = 8;

  localparam int OpW     = 3;
  localparam int InPageW = 12;
  localparam int InAsidW = 8;
  localparam int InFrmW  = 6;
  localparam int StatW   = 2;
  localparam int OutFrmW = 5;
  localparam int CntW    = 6;
  localparam int StampW  = 32;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP  = 3'd0,
    OP_TOUCH   = 3'd1,
    OP_DIRTY   = 3'd2,
    OP_MAP     = 3'd3,
    OP_INVAL   = 3'd4,
    OP_PROTECT = 3'd5,
    OP_RESTORE = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input transaction
    logic exec;     // perform operation, register result
  } ctl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/iptlru_ctrl.sv =====
// ----------------------------------------------------------------------------
// iptlru_ctrl
// sequencer: capture, execute, present result
// ----------------------------------------------------------------------------
`default_nettype none
module iptlru_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output iptlru_pkg::ctl_cmd_t    cmd
);
  import iptlru_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/iptlru_dp.sv =====
// ----------------------------------------------------------------------------
// iptlru_dp
// frame table registers, associative match and lru search
// ----------------------------------------------------------------------------
`default_nettype none
module iptlru_dp #(
  parameter int FRAMES    = iptlru_pkg::FramesDef,
  parameter int PAGE_BITS = iptlru_pkg::PageBitsDef,
  parameter int ASID_BITS = iptlru_pkg::AsidBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire iptlru_pkg::ctl_cmd_t          cmd,
  input  wire logic [iptlru_pkg::OpW-1:0]    in_operation,
  input  wire logic [iptlru_pkg::InPageW-1:0] in_virtual_page,
  input  wire logic [iptlru_pkg::InAsidW-1:0] in_asid,
  input  wire logic [iptlru_pkg::InFrmW-1:0] in_frame,
  output logic [iptlru_pkg::StatW-1:0]       out_status,
  output logic                               out_entry_valid_out,
  output logic [iptlru_pkg::OutFrmW-1:0]     out_frame_out,
  output logic                               out_evicted,
  output logic [iptlru_pkg::InPageW-1:0]     out_evicted_page,
  output logic [iptlru_pkg::InAsidW-1:0]     out_evicted_asid,
  output logic                               out_evicted_dirty,
  output logic [iptlru_pkg::CntW-1:0]        out_changed_count
);
  import iptlru_pkg::*;

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int NP = 1 << FW;

  logic [PAGE_BITS-1:0] page_r  [FRAMES];
  logic [ASID_BITS-1:0] asid_r  [FRAMES];
  logic [StampW-1:0]    stamp_r [FRAMES];
  logic [FRAMES-1:0]    valid_r, dirty_r, used_r;
  logic [StampW-1:0]    clock_r;

  // captured transaction
  op_t                  op_r;
  logic [PAGE_BITS-1:0] vp_r;
  logic [ASID_BITS-1:0] as_r;
  logic [InFrmW-1:0]    fr_r;

  logic [PAGE_BITS-1:0] vp_in;
  logic [ASID_BITS-1:0] as_in;

  always_comb begin
    vp_in = '0;
    as_in = '0;
    for (int b = 0; b < PAGE_BITS; b++) if (b < InPageW) vp_in[b] = in_virtual_page[b];
    for (int b = 0; b < ASID_BITS; b++) if (b < InAsidW) as_in[b] = in_asid[b];
  end

  // lru minimum and asid count as balanced trees in the execute cycle,
  // the lower index kept on a tie; padding leaves never win
  logic [FRAMES-1:0] hit, asm;
  logic [FW-1:0]     hit_idx, free_idx, lru_idx;
  logic              hit_any, free_any;
  logic [CW-1:0]     cnt;
  logic [StampW-1:0] tr_stamp [2*NP];
  logic [FW-1:0]     tr_idx   [2*NP];
  logic [CW-1:0]     tr_cnt   [2*NP];

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    hit_any  = 1'b0;
    free_any = 1'b0;
    for (int f = 0; f < FRAMES; f++) begin
      hit[f] = used_r[f] && page_r[f] == vp_r && asid_r[f] == as_r;
      asm[f] = used_r[f] && asid_r[f] == as_r && (valid_r[f] != (op_r == OP_RESTORE));
    end
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (hit[f]) begin
        hit_any = 1'b1;
        hit_idx = FW'(f);
      end
      if (!used_r[f]) begin
        free_any = 1'b1;
        free_idx = FW'(f);
      end
    end
    tr_stamp[0] = '0;
    tr_idx[0]   = '0;
    tr_cnt[0]   = '0;
    for (int n = 0; n < NP; n++) begin
      tr_stamp[NP+n] = '1;
      tr_idx[NP+n]   = FW'(n);
      tr_cnt[NP+n]   = '0;
    end
    for (int n = 0; n < FRAMES; n++) begin
      tr_stamp[NP+n] = stamp_r[n];
      tr_cnt[NP+n]   = CW'(asm[n]);
    end
    for (int n = NP - 1; n >= 1; n--) begin
      if (tr_stamp[2*n+1] < tr_stamp[2*n]) begin
        tr_stamp[n] = tr_stamp[2*n+1];
        tr_idx[n]   = tr_idx[2*n+1];
      end else begin
        tr_stamp[n] = tr_stamp[2*n];
        tr_idx[n]   = tr_idx[2*n];
      end
      tr_cnt[n] = tr_cnt[2*n] + tr_cnt[2*n+1];
    end
    lru_idx = tr_idx[1];
    cnt     = tr_cnt[1];
  end

  logic          fr_ok;
  logic [FW-1:0] fi;
  logic [FW-1:0] pick;
  assign fr_ok = {1'b0, fr_r} < (InFrmW + 1)'(FRAMES);
  assign fi    = fr_r[FW-1:0];
  assign pick  = free_any ? free_idx : lru_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_operation);
      vp_r <= vp_in;
      as_r <= as_in;
      fr_r <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      used_r  <= '0;
      clock_r <= '0;
      for (int f = 0; f < FRAMES; f++) begin
        page_r[f]  <= '0;
        asid_r[f]  <= '0;
        stamp_r[f] <= '0;
      end
    end else if (cmd.exec) begin
      case (op_r)
        OP_TOUCH: if (fr_ok && used_r[fi]) begin
          stamp_r[fi] <= clock_r;
          if (clock_r != '1) clock_r <= clock_r + 1'b1;
        end
        OP_DIRTY: if (fr_ok && used_r[fi]) dirty_r[fi] <= 1'b1;
        OP_INVAL: if (fr_ok && used_r[fi]) begin
          page_r[fi]  <= '0;
          asid_r[fi]  <= '0;
          valid_r[fi] <= 1'b0;
          dirty_r[fi] <= 1'b0;
          stamp_r[fi] <= '0;
          used_r[fi]  <= 1'b0;
        end
        OP_MAP: begin
          page_r[pick]  <= vp_r;
          asid_r[pick]  <= as_r;
          valid_r[pick] <= 1'b1;
          dirty_r[pick] <= 1'b0;
          stamp_r[pick] <= '0;
          used_r[pick]  <= 1'b1;
        end
        OP_PROTECT, OP_RESTORE: valid_r <= valid_r ^ asm;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status          <= ST_OK;
      out_entry_valid_out <= 1'b0;
      out_frame_out       <= '0;
      out_evicted         <= 1'b0;
      out_evicted_page    <= '0;
      out_evicted_asid    <= '0;
      out_evicted_dirty   <= 1'b0;
      out_changed_count   <= '0;
      case (op_r)
        OP_LOOKUP: begin
          if (hit_any) begin
            out_entry_valid_out <= valid_r[hit_idx];
            out_frame_out       <= OutFrmW'(hit_idx);
          end else begin
            out_status <= ST_NONE;
          end
        end
        OP_TOUCH, OP_DIRTY, OP_INVAL: begin
          if (!fr_ok)           out_status <= ST_RANGE;
          else if (!used_r[fi]) out_status <= ST_NONE;
        end
        OP_MAP: begin
          out_frame_out <= OutFrmW'(pick);
          if (!free_any) begin
            out_evicted       <= 1'b1;
            out_evicted_page  <= InPageW'(page_r[pick]);
            out_evicted_asid  <= InAsidW'(asid_r[pick]);
            out_evicted_dirty <= dirty_r[pick];
          end
        end
        OP_PROTECT, OP_RESTORE: out_changed_count <= CntW'(cnt);
        default: out_status <= ST_NONE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/inverted_page_table_lru_top.sv =====
// ----------------------------------------------------------------------------
// inverted_page_table_lru_top
// inverted page table of physical frames with lru replacement
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall   operation, page, asid, frame
// out_     output     out_valid / out_stall status, frame, eviction, count
//
// every transaction passes through capture, execute and present result, in that order.
// the execute cycle holds the associative match and the lru minimum search.
// reset clears the whole table at once; no clearing pass.
// the input stays stalled until the result transaction is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "inverted_page_table_lru_top_defines.svh"
module inverted_page_table_lru_top #(
  parameter int FRAMES    = iptlru_pkg::FramesDef,
  parameter int PAGE_BITS = iptlru_pkg::PageBitsDef,
  parameter int ASID_BITS = iptlru_pkg::AsidBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [iptlru_pkg::OpW-1:0]    in_operation,
  input  wire logic [iptlru_pkg::InPageW-1:0] in_virtual_page,
  input  wire logic [iptlru_pkg::InAsidW-1:0] in_asid,
  input  wire logic [iptlru_pkg::InFrmW-1:0] in_frame,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [iptlru_pkg::StatW-1:0]       out_status,
  output logic                               out_entry_valid_out,
  output logic [iptlru_pkg::OutFrmW-1:0]     out_frame_out,
  output logic                               out_evicted,
  output logic [iptlru_pkg::InPageW-1:0]     out_evicted_page,
  output logic [iptlru_pkg::InAsidW-1:0]     out_evicted_asid,
  output logic                               out_evicted_dirty,
  output logic [iptlru_pkg::CntW-1:0]        out_changed_count
);
  import iptlru_pkg::*;

  ctl_cmd_t cmd;

  iptlru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  iptlru_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .ASID_BITS (ASID_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_operation        (in_operation),
    .in_virtual_page     (in_virtual_page),
    .in_asid             (in_asid),
    .in_frame            (in_frame),
    .out_status          (out_status),
    .out_entry_valid_out (out_entry_valid_out),
    .out_frame_out       (out_frame_out),
    .out_evicted         (out_evicted),
    .out_evicted_page    (out_evicted_page),
    .out_evicted_asid    (out_evicted_asid),
    .out_evicted_dirty   (out_evicted_dirty),
    .out_changed_count   (out_changed_count)
  );

  `IPT_ASSERT_NEXT(a_load_execs, clk, rst_n, cmd.load, cmd.exec)
  `IPT_ASSERT_NEXT(a_exec_shows, clk, rst_n, cmd.exec, out_valid)
  `IPT_ASSERT_IMPL(a_busy_stalls, clk, rst_n, out_valid || cmd.exec, in_stall)

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// inverted page table testbench
// drives random and directed page table operations with bursty input and a
// stalling result side, and checks every result against an in-bench table
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import iptlru_pkg::*;

  localparam int NFRM = 32;

  typedef struct packed {
    op_t                op;
    logic [InPageW-1:0] page;
    logic [InAsidW-1:0] asid;
    logic [InFrmW-1:0]  frm;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic                ent_valid;
    logic [OutFrmW-1:0]  frm;
    logic                evicted;
    logic [InPageW-1:0]  ev_page;
    logic [InAsidW-1:0]  ev_asid;
    logic                ev_dirty;
    logic [CntW-1:0]     count;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OpW-1:0] in_operation = '0;
  logic [InPageW-1:0] in_virtual_page = '0;
  logic [InAsidW-1:0] in_asid = '0;
  logic [InFrmW-1:0] in_frame = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [StatW-1:0] out_status;
  logic out_entry_valid_out;
  logic [OutFrmW-1:0] out_frame_out;
  logic out_evicted;
  logic [InPageW-1:0] out_evicted_page;
  logic [InAsidW-1:0] out_evicted_asid;
  logic out_evicted_dirty;
  logic [CntW-1:0] out_changed_count;

  inverted_page_table_lru_top DUT (.*);

  // shadow page table
  logic [InPageW-1:0] tbl_page [NFRM];
  logic [InAsidW-1:0] tbl_asid [NFRM];
  logic               tbl_valid [NFRM];
  logic               tbl_dirty [NFRM];
  logic [StampW-1:0]  tbl_stamp [NFRM];
  logic               tbl_used [NFRM];
  logic [StampW-1:0]  use_clock;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    n_sent = 0, n_checked = 0, n_evictions = 0;
  bit    hold_input = 0;
  int    gap_left = 0, burst_left = 0;
  int    stall_phase = 0;

  function automatic resp_t table_apply(req_t r);
    resp_t o;
    int pick;
    int cnt;
    logic want;
    o = '0;
    case (r.op)
      OP_LOOKUP: begin
        o.status = ST_NONE;
        for (int f = 0; f < NFRM; f++) begin
          if (tbl_used[f] && tbl_page[f] == r.page && tbl_asid[f] == r.asid) begin
            o.status = ST_OK;
            o.ent_valid = tbl_valid[f];
            o.frm = f[OutFrmW-1:0];
            break;
          end
        end
      end
      OP_TOUCH, OP_DIRTY, OP_INVAL: begin
        if (r.frm >= NFRM) o.status = ST_RANGE;
        else if (!tbl_used[r.frm]) o.status = ST_NONE;
        else if (r.op == OP_TOUCH) begin
          tbl_stamp[r.frm] = use_clock;
          if (use_clock != '1) use_clock++;
        end else if (r.op == OP_DIRTY) tbl_dirty[r.frm] = 1'b1;
        else begin
          tbl_page[r.frm] = '0; tbl_asid[r.frm] = '0; tbl_valid[r.frm] = 0;
          tbl_dirty[r.frm] = 0; tbl_stamp[r.frm] = '0; tbl_used[r.frm] = 0;
        end
      end
      OP_MAP: begin
        pick = -1;
        for (int f = 0; f < NFRM; f++)
          if (!tbl_used[f]) begin pick = f; break; end
        if (pick < 0) begin
          pick = 0;
          for (int f = 1; f < NFRM; f++)
            if (tbl_stamp[f] < tbl_stamp[pick]) pick = f;
          o.evicted = 1'b1;
          o.ev_page = tbl_page[pick];
          o.ev_asid = tbl_asid[pick];
          o.ev_dirty = tbl_dirty[pick];
        end
        tbl_page[pick] = r.page; tbl_asid[pick] = r.asid; tbl_valid[pick] = 1;
        tbl_dirty[pick] = 0; tbl_stamp[pick] = '0; tbl_used[pick] = 1;
        o.frm = pick[OutFrmW-1:0];
      end
      OP_PROTECT, OP_RESTORE: begin
        cnt = 0;
        want = (r.op == OP_RESTORE);
        for (int f = 0; f < NFRM; f++)
          if (tbl_used[f] && tbl_asid[f] == r.asid && tbl_valid[f] != want) begin
            tbl_valid[f] = want;
            cnt++;
          end
        o.count = cnt[CntW-1:0];
      end
      default: o.status = ST_NONE;
    endcase
    return o;
  endfunction

  function automatic req_t make_req(op_t op, int page, int asid, int frm);
    req_t r;
    r.op = op;
    r.page = page[InPageW-1:0];
    r.asid = asid[InAsidW-1:0];
    r.frm = frm[InFrmW-1:0];
    return r;
  endfunction

  task automatic queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // sender: bursts with gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_resps = {expected_resps, table_apply(make_req(op_t'(in_operation),
          in_virtual_page, in_asid, in_frame))};
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) gap_left--;
        if (pending_reqs.size() > 0 && !hold_input && gap_left == 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_operation <= r.op;
          in_virtual_page <= r.page;
          in_asid <= r.asid;
          in_frame <= r.frm;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else in_valid <= 1'b0;
      end
    end
  end

  // receiver: stalls in its own pattern, checks each result transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        resp_t e;
        n_checked++;
        if (expected_resps.size() == 0) begin
          $error("result transaction with none expected");
          errors++;
        end else begin
          e = expected_resps.pop_front();
          if (out_status != e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++; end
          if (out_entry_valid_out != e.ent_valid) begin
            $error("entry_valid_out exp %0d got %0d", e.ent_valid,
              out_entry_valid_out); errors++; end
          if (out_frame_out != e.frm) begin
            $error("frame_out exp %0d got %0d", e.frm, out_frame_out); errors++; end
          if (out_evicted != e.evicted) begin
            $error("evicted exp %0d got %0d", e.evicted, out_evicted); errors++; end
          if (out_evicted_page != e.ev_page) begin
            $error("evicted_page exp %0d got %0d", e.ev_page, out_evicted_page);
            errors++; end
          if (out_evicted_asid != e.ev_asid) begin
            $error("evicted_asid exp %0d got %0d", e.ev_asid, out_evicted_asid);
            errors++; end
          if (out_evicted_dirty != e.ev_dirty) begin
            $error("evicted_dirty exp %0d got %0d", e.ev_dirty, out_evicted_dirty);
            errors++; end
          if (out_changed_count != e.count) begin
            $error("changed_count exp %0d got %0d", e.count, out_changed_count);
            errors++; end
          if (e.evicted) n_evictions++;
        end
      end
      stall_phase = (stall_phase + 1) % 400;
      // quiet stretch, then a heavy and a light stall mix
      if (stall_phase < 80) out_stall <= 1'b0;
      else if (stall_phase < 240) out_stall <= ($urandom_range(0, 1) == 0);
      else out_stall <= ($urandom_range(0, 5) == 0);
    end
  end

  initial begin
    int asids[4];
    int k;
    for (int f = 0; f < NFRM; f++) begin
      tbl_page[f] = '0; tbl_asid[f] = '0; tbl_valid[f] = 0;
      tbl_dirty[f] = 0; tbl_stamp[f] = '0; tbl_used[f] = 0;
    end
    use_clock = '0;

    // directed: empty table, range limits, field extremes, all opcodes
    queue_req(make_req(OP_LOOKUP, 0, 1, 0));
    queue_req(make_req(OP_TOUCH, 0, 1, 0));
    queue_req(make_req(OP_DIRTY, 0, 1, 31));
    queue_req(make_req(OP_INVAL, 0, 1, 32));
    queue_req(make_req(OP_TOUCH, 0, 1, 63));
    queue_req(make_req(OP_MAP, 4095, 255, 0));
    queue_req(make_req(OP_MAP, 0, 1, 0));
    queue_req(make_req(OP_MAP, 4095, 255, 0));
    queue_req(make_req(OP_LOOKUP, 4095, 255, 0));
    queue_req(make_req(OP_LOOKUP, 4095, 254, 0));
    queue_req(make_req(OP_TOUCH, 0, 1, 1));
    queue_req(make_req(OP_DIRTY, 0, 1, 0));
    queue_req(make_req(OP_PROTECT, 0, 255, 0));
    queue_req(make_req(OP_LOOKUP, 4095, 255, 0));
    queue_req(make_req(OP_PROTECT, 0, 255, 0));
    queue_req(make_req(OP_RESTORE, 0, 255, 0));
    queue_req(make_req(OP_INVAL, 0, 1, 1));
    queue_req(make_req(OP_INVAL, 0, 1, 1));
    queue_req(make_req(OP_NONE, 4095, 255, 63));
    queue_req(make_req(OP_RESTORE, 0, 7, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // once the directed results have all come back, pause the sender while random requests are queued
    wait (pending_reqs.size() == 0 && !in_valid && expected_resps.size() == 0);
    hold_input = 1;
    @(posedge clk);

    // random: mostly working-set traffic on a few asids, some pure noise
    for (int i = 0; i < 4; i++) asids[i] = $urandom_range(1, 255);
    for (int i = 0; i < 830; i++) begin
      req_t r;
      k = $urandom_range(0, 99);
      r.page = InPageW'($urandom_range(0, 15));
      r.asid = InAsidW'(asids[$urandom_range(0, 3)]);
      r.frm = ($urandom_range(0, 9) == 0) ? InFrmW'($urandom_range(32, 63))
                                          : InFrmW'($urandom_range(0, 31));
      if (k < 10) begin
        r.page = InPageW'($urandom);
        r.asid = InAsidW'($urandom);
        r.frm = InFrmW'($urandom);
        r.op = op_t'($urandom_range(0, 7));
      end else if (k < 30) r.op = OP_MAP;
      else if (k < 50) r.op = OP_TOUCH;
      else if (k < 68) r.op = OP_LOOKUP;
      else if (k < 78) r.op = OP_DIRTY;
      else if (k < 86) r.op = OP_INVAL;
      else if (k < 93) r.op = OP_PROTECT;
      else r.op = OP_RESTORE;
      queue_req(r);
    end
    hold_input = 0;

    wait (pending_reqs.size() == 0 && !in_valid && expected_resps.size() == 0);
    repeat (20) @(posedge clk);
    $display("sent %0d transactions, checked %0d results, %0d with eviction",
      n_sent, n_checked, n_evictions);
    if (errors == 0 && expected_resps.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
